// ===== src/cds_pkg.sv =====
// Shared types, constants and saturating helpers for the smoothing block.
// Used by cds_mul, cds_div and the top level; depends on nothing.
`timescale 1ns / 1ps
package cds_pkg;
   typedef logic signed [63:0] wide_type;

   localparam int DIV_NW = 49;
   localparam logic [62:0] ULIM = 63'h4000_0000_0000_0000;
   localparam logic signed [64:0] LIM65 = 65'sh0_4000_0000_0000_0000;
   localparam wide_type LIMW = 64'sh4000_0000_0000_0000;
   localparam logic [31:0] ST_MIN = 32'd7;
   localparam wide_type K048 = 64'sd31457;
   localparam wide_type K0235 = 64'sd15401;
   localparam logic [64:0] ONE_Q = 65'd65536;
   localparam logic REG_SMOOTH_TIME = 1'b0;
   localparam logic REG_MAX_SPEED = 1'b1;

   function automatic wide_type clampw(input logic signed [64:0] v);
      wide_type r;
      if (v > LIM65) r = LIMW;
      else if (v < -LIM65) r = -LIMW;
      else r = v[63:0];
      return r;
   endfunction

   function automatic wide_type sadd(input wide_type a, input wide_type b);
      wide_type ca;
      wide_type cb;
      logic signed [64:0] s;
      ca = clampw({a[63], a});
      cb = clampw({b[63], b});
      s = {ca[63], ca} + {cb[63], cb};
      return clampw(s);
   endfunction

   function automatic logic [62:0] mag63(input wide_type a);
      wide_type c;
      wide_type m;
      c = clampw({a[63], a});
      m = -c;
      return c[63] ? m[62:0] : c[62:0];
   endfunction

   function automatic logic [62:0] satu(input logic [64:0] v);
      return (v > {2'b00, ULIM}) ? ULIM : v[62:0];
   endfunction

   function automatic logic signed [31:0] sat32(input wide_type v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
      else if (v < -64'sd2147483648) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

// ===== src/cds_mul.sv =====
// Iterative saturating Q16.16 multiplier built on one 32 by 32 multiplier.
// Four partial products, one per cycle; depends on cds_pkg.
`timescale 1ns / 1ps
module cds_mul
   import cds_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  wide_type a,
   input  wide_type b,
   output logic     done,
   output wide_type res,
   output logic [63:0] raw
);
   logic [62:0]  ma_ff, mb_ff;
   logic         neg_ff, run_ff, done_ff;
   logic [1:0]   cnt_ff;
   logic [126:0] acc_ff;
   logic [31:0]  opa, opb;
   logic [63:0]  part;
   logic [126:0] term;
   logic [62:0]  mag;
   wide_type     smag;

   always_comb begin
      opa = cnt_ff[0] ? {1'b0, ma_ff[62:32]} : ma_ff[31:0];
      opb = cnt_ff[1] ? {1'b0, mb_ff[62:32]} : mb_ff[31:0];
      part = opa * opb;
      case (cnt_ff)
         2'd0: term = 127'(part);
         2'd3: term = 127'(part) << 64;
         default: term = 127'(part) << 32;
      endcase
      mag = (acc_ff[126:16] > 111'(ULIM)) ? ULIM : acc_ff[78:16];
      smag = {1'b0, mag};
      res = neg_ff ? -smag : smag;
      raw = acc_ff[63:0];
      done = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            ma_ff <= mag63(a);
            mb_ff <= mag63(b);
            neg_ff <= a[63] != b[63];
            acc_ff <= '0;
            cnt_ff <= 2'd0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            acc_ff <= acc_ff + term;
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

// ===== src/cds_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on cds_pkg for the numerator width.
`timescale 1ns / 1ps
module cds_div
   import cds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] num,
   input  logic [62:0]       den,
   output logic              done,
   output logic [DIV_NW-1:0] quo
);
   logic [63:0]       rem_ff;
   logic [DIV_NW-1:0] num_ff, quo_ff;
   logic [62:0]       den_ff;
   logic [5:0]        cnt_ff;
   logic              run_ff, done_ff;
   logic [63:0]       trial;
   logic              ge;

   always_comb begin
      trial = {rem_ff[62:0], num_ff[DIV_NW-1]};
      ge = trial >= {1'b0, den_ff};
      done = done_ff;
      quo = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= '0;
            num_ff <= num;
            den_ff <= den;
            quo_ff <= '0;
            cnt_ff <= 6'(DIV_NW);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= ge ? trial - {1'b0, den_ff} : trial;
            quo_ff <= {quo_ff[DIV_NW-2:0], ge};
            num_ff <= num_ff << 1;
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

// ===== src/cds_sqrt.sv =====
// Integer square root of a 64-bit value, two radicand bits per cycle.
// Depends on nothing; 32 steps per root.
`timescale 1ns / 1ps
module cds_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] rad,
   output logic        done,
   output logic [32:0] root
);
   logic [63:0] n_ff, res_ff, bit_ff;
   logic        run_ff, done_ff;
   logic [64:0] rb;

   always_comb begin
      rb = {1'b0, res_ff} + {1'b0, bit_ff};
      done = done_ff;
      root = res_ff[32:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            n_ff <= rad;
            res_ff <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if ({1'b0, n_ff} >= rb) begin
               n_ff <= n_ff - rb[63:0];
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

// ===== src/critically_damped_smoothing_2d.sv =====
// Top level of the critically damped 2D smoothing block: sequencer and state.
// Depends on cds_pkg, cds_mul, cds_div and cds_sqrt.
//
// Usage: each item on req_ carries a current position, a target and a time
// step; one result item on rsp_ gives the new position and the new velocity.
// The velocity is kept between items. csr_ writes smooth_time (index 0) and
// max_speed (index 1); the user must write them only while the block is idle,
// as the block itself does not enforce this. Each item runs 20 multiplies on
// the shared iterative multiplier, two divisions and one square root for the
// vector length. When the offset is limited by the speed limit, two more
// divisions and multiplies are added, and a very long offset adds two more
// multiplies. req_tready is high only while no item is in work. The result
// waits in an output register; if the receiver stalls, the block still takes
// and works one new item, but holds that item until the pending result has
// been taken. Reset clears the velocity, the sequencer and the output, and
// restores the register defaults.
`timescale 1ns / 1ps
module critically_damped_smoothing_2d
   import cds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // current_x, current_y, target_x, target_y, delta_time, zero fill
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // next_x, next_y, speed_x, speed_y
   output logic [127:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);
   typedef enum logic [4:0] {
      S_IDLE, S_OMEGA, S_X, S_X2, S_X3, S_P, S_Q, S_D, S_ML, S_SQ, S_HSQ,
      S_SQRT, S_UX, S_CV, S_A, S_T3, S_C, S_NV, S_G, S_DOT, S_OUT
   } state_type;

   state_type          state_ff;
   logic               busy_ff, axis_ff, half_ff, rsp_valid_ff;
   logic [31:0]        smooth_ff, st_ff, omega_ff;
   logic [30:0]        maxspd_ff;
   logic [16:0]        dt_ff, d_ff;
   logic [62:0]        x_ff, x2_ff, x3_ff, den_ff, maxlen_ff;
   logic [63:0]        s1_ff, n_ff;
   logic [33:0]        len_ff;
   logic signed [31:0] c_ff [2];
   logic signed [31:0] t_ff [2];
   logic signed [31:0] o_ff [2];
   logic signed [31:0] vel_ff [2];
   wide_type           vx_ff [2];
   wide_type           t3_ff [2];
   wide_type           nv_ff [2];
   wide_type           tmp_ff, dacc_ff;
   logic [127:0]       rsp_data_ff;

   logic               mul_start, div_start, sqrt_start;
   logic               mul_done, div_done, sqrt_done, unit_done;
   wide_type           mul_a, mul_b, mul_res;
   logic [63:0]        mul_raw;
   logic [DIV_NW-1:0]  div_num, div_quo;
   logic [62:0]        div_den;
   logic [32:0]        sq_root;
   logic [31:0]        absv;
   logic [64:0]        sum65;
   logic [33:0]        len_new;
   wide_type           vsel, csel, tsel, gsel, dot, qs;

   cds_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .res(mul_res), .raw(mul_raw)
   );

   cds_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quo(div_quo)
   );

   cds_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .rad(n_ff),
      .done(sqrt_done), .root(sq_root)
   );

   always_comb begin
      vsel = vx_ff[axis_ff];
      csel = 64'(c_ff[axis_ff]);
      tsel = 64'(t_ff[axis_ff]);
      absv = mag63(vsel) >> 0 > 63'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(mag63(vsel));
      gsel = csel - vsel;
      sum65 = {1'b0, s1_ff} + {1'b0, mul_raw};
      len_new = half_ff ? {sq_root, 1'b0} : {1'b0, sq_root};
      dot = sadd(dacc_ff, mul_res);
      qs = 64'(div_quo);
      unit_done = mul_done | div_done | sqrt_done;
      mul_start = !busy_ff && (state_ff inside {S_X, S_X2, S_X3, S_P, S_Q, S_ML,
         S_SQ, S_HSQ, S_CV, S_A, S_T3, S_C, S_NV, S_G, S_DOT});
      div_start = !busy_ff && (state_ff inside {S_OMEGA, S_D, S_UX});
      sqrt_start = !busy_ff && (state_ff == S_SQRT);
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_X: begin
            mul_a = 64'(omega_ff);
            mul_b = 64'(dt_ff);
         end
         S_X2: begin
            mul_a = 64'(x_ff);
            mul_b = 64'(x_ff);
         end
         S_X3: begin
            mul_a = 64'(x2_ff);
            mul_b = 64'(x_ff);
         end
         S_P: begin
            mul_a = 64'(x2_ff);
            mul_b = K048;
         end
         S_Q: begin
            mul_a = 64'(x3_ff);
            mul_b = K0235;
         end
         S_ML: begin
            mul_a = 64'(maxspd_ff);
            mul_b = 64'(st_ff);
         end
         S_SQ: begin
            mul_a = 64'(absv);
            mul_b = 64'(absv);
         end
         S_HSQ: begin
            mul_a = 64'(absv >> 1);
            mul_b = 64'(absv >> 1);
         end
         S_CV: begin
            mul_a = tmp_ff;
            mul_b = 64'(maxlen_ff);
         end
         S_A: begin
            mul_a = vsel;
            mul_b = 64'(omega_ff);
         end
         S_T3: begin
            mul_a = tmp_ff;
            mul_b = 64'(dt_ff);
         end
         S_C: begin
            mul_a = t3_ff[axis_ff];
            mul_b = 64'(omega_ff);
         end
         S_NV: begin
            mul_a = tmp_ff;
            mul_b = 64'(d_ff);
         end
         S_G: begin
            mul_a = sadd(vsel, t3_ff[axis_ff]);
            mul_b = 64'(d_ff);
         end
         S_DOT: begin
            mul_a = tsel - csel;
            mul_b = 64'(o_ff[axis_ff]) - tsel;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      case (state_ff)
         S_OMEGA: begin
            div_num = DIV_NW'(64'h2_0000_0000);
            div_den = 63'(st_ff);
         end
         S_D: begin
            div_num = DIV_NW'(64'h1_0000_0000);
            div_den = den_ff;
         end
         default: begin
            div_num = DIV_NW'({absv, 16'h0000});
            div_den = 63'(len_ff);
         end
      endcase
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
         axis_ff <= 1'b0;
         half_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         smooth_ff <= 32'd65536;
         maxspd_ff <= 31'h7FFF_FFFF;
         vel_ff[0] <= '0;
         vel_ff[1] <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_SMOOTH_TIME) smooth_ff <= csr_wdata;
            else maxspd_ff <= csr_wdata[30:0];
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (mul_start || div_start || sqrt_start) busy_ff <= 1'b1;
         if (unit_done) busy_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  c_ff[0] <= req_tdata[31:0];
                  c_ff[1] <= req_tdata[63:32];
                  t_ff[0] <= req_tdata[95:64];
                  t_ff[1] <= req_tdata[127:96];
                  dt_ff <= req_tdata[144:128];
                  vx_ff[0] <= 64'($signed(req_tdata[31:0])) - 64'($signed(req_tdata[95:64]));
                  vx_ff[1] <= 64'($signed(req_tdata[63:32]))
                     - 64'($signed(req_tdata[127:96]));
                  st_ff <= (smooth_ff < ST_MIN) ? ST_MIN : smooth_ff;
                  axis_ff <= 1'b0;
                  state_ff <= S_OMEGA;
               end
            end
            S_OMEGA: if (unit_done) begin
               omega_ff <= div_quo[31:0];
               state_ff <= S_X;
            end
            S_X: if (unit_done) begin
               x_ff <= mul_res[62:0];
               state_ff <= S_X2;
            end
            S_X2: if (unit_done) begin
               x2_ff <= mul_res[62:0];
               state_ff <= S_X3;
            end
            S_X3: if (unit_done) begin
               x3_ff <= mul_res[62:0];
               state_ff <= S_P;
            end
            S_P: if (unit_done) begin
               den_ff <= satu(ONE_Q + {2'b00, x_ff} + {2'b00, mul_res[62:0]});
               state_ff <= S_Q;
            end
            S_Q: if (unit_done) begin
               den_ff <= satu({2'b00, den_ff} + {2'b00, mul_res[62:0]});
               state_ff <= S_D;
            end
            S_D: if (unit_done) begin
               d_ff <= div_quo[16:0];
               state_ff <= S_ML;
            end
            S_ML: if (unit_done) begin
               maxlen_ff <= mul_res[62:0];
               axis_ff <= 1'b0;
               state_ff <= S_SQ;
            end
            S_SQ, S_HSQ: if (unit_done) begin
               if (!axis_ff) begin
                  s1_ff <= mul_raw;
                  axis_ff <= 1'b1;
               end else begin
                  axis_ff <= 1'b0;
                  n_ff <= sum65[63:0];
                  if (state_ff == S_SQ && sum65[64]) begin
                     half_ff <= 1'b1;
                     state_ff <= S_HSQ;
                  end else begin
                     half_ff <= (state_ff == S_HSQ);
                     state_ff <= S_SQRT;
                  end
               end
            end
            S_SQRT: if (unit_done) begin
               len_ff <= len_new;
               axis_ff <= 1'b0;
               state_ff <= ({29'd0, len_new} > maxlen_ff) ? S_UX : S_A;
            end
            S_UX: if (unit_done) begin
               tmp_ff <= vsel[63] ? -qs : qs;
               state_ff <= S_CV;
            end
            S_CV: if (unit_done) begin
               vx_ff[axis_ff] <= mul_res;
               axis_ff <= !axis_ff;
               state_ff <= axis_ff ? S_A : S_UX;
            end
            S_A: if (unit_done) begin
               tmp_ff <= sadd(64'(vel_ff[axis_ff]), mul_res);
               state_ff <= S_T3;
            end
            S_T3: if (unit_done) begin
               t3_ff[axis_ff] <= mul_res;
               state_ff <= S_C;
            end
            S_C: if (unit_done) begin
               tmp_ff <= sadd(64'(vel_ff[axis_ff]), -mul_res);
               state_ff <= S_NV;
            end
            S_NV: if (unit_done) begin
               nv_ff[axis_ff] <= mul_res;
               state_ff <= S_G;
            end
            S_G: if (unit_done) begin
               o_ff[axis_ff] <= sat32(sadd(gsel, mul_res));
               axis_ff <= !axis_ff;
               state_ff <= axis_ff ? S_DOT : S_A;
            end
            S_DOT: if (unit_done) begin
               if (!axis_ff) begin
                  dacc_ff <= mul_res;
                  axis_ff <= 1'b1;
               end else begin
                  axis_ff <= 1'b0;
                  if (dot > 0) begin
                     o_ff[0] <= t_ff[0];
                     o_ff[1] <= t_ff[1];
                     vel_ff[0] <= '0;
                     vel_ff[1] <= '0;
                  end else begin
                     vel_ff[0] <= sat32(nv_ff[0]);
                     vel_ff[1] <= sat32(nv_ff[1]);
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff <= {vel_ff[1], vel_ff[0], o_ff[1], o_ff[0]};
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_done, div_done, sqrt_done}))
      else $error("more than one arithmetic unit finished at once");

   assert property (@(posedge clock) disable iff (reset)
      unit_done |-> busy_ff)
      else $error("arithmetic unit finished without an issued operation");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block took a second item while one is in work");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (st_ff >= ST_MIN))
      else $error("smooth time below its minimum during an item");
endmodule
